// ----- design/tcer_pkg.sv -----
`timescale 1ns / 1ps
package tcer_pkg;

  // Sine and cosine format: signed Q1.15
  localparam int SIN_W      = 16;
  localparam int FRAC       = 15;
  localparam int ROUND_HALF = 1 << (FRAC - 1);
  localparam int SIN_MAX    = 32767;

  // Guard bits on vertex offsets: difference plus growth through three rotations
  localparam int DEXT = 3;

  // Pipeline layout
  localparam int SINE_STAGES = 7;
  localparam int CEN_STAGES  = 5;
  localparam int NSTAGE      = 14;

  // Taylor coefficients of sin(pi/2 * t), unsigned Q1.30
  localparam logic [30:0] K_C1 = 31'd1686629713;
  localparam logic [30:0] K_C3 = 31'd693598668;
  localparam logic [30:0] K_C5 = 31'd85569306;
  localparam logic [30:0] K_C7 = 31'd5026995;
  localparam logic [30:0] K_C9 = 31'd172272;

  localparam logic [30:0] HORNER_K [4] = '{K_C7, K_C5, K_C3, K_C1};

  typedef struct packed {
    logic signed [SIN_W-1:0] sin_v;
    logic signed [SIN_W-1:0] cos_v;
  } sc_t;

  // Q1.30 product, truncated
  function automatic logic [30:0] mul_q30(input logic [30:0] a, input logic [30:0] b);
    logic [61:0] p;
    p = 62'(a) * 62'(b);
    return p[60:30];
  endfunction

endpackage

// ----- design/tcer_sine.sv -----
`timescale 1ns / 1ps
module tcer_sine
  import tcer_pkg::*;
#(
  parameter int ANGLE_WIDTH = 16
) (
  input  logic                    clk,
  input  logic [SINE_STAGES-1:0]  adv,
  input  logic [ANGLE_WIDTH-1:0]  angle,
  output logic signed [SIN_W-1:0] sine
);

  localparam int RW  = ANGLE_WIDTH - 1;
  localparam int PAD = 32 - ANGLE_WIDTH;
  localparam logic [RW-1:0] QUARTER = RW'(1) << (ANGLE_WIDTH - 2);

  logic [RW-1:0]   rr;
  logic [30:0]     t_in;
  logic [30:0]     t_q   [0:5];
  logic            neg_q [0:5];
  logic [30:0]     t2_q  [1:5];
  logic [30:0]     acc_q [2:5];
  logic [30:0]     pr;
  logic [31:0]     rsum;
  logic [16:0]     rnd;
  logic [14:0]     mag;
  logic signed [SIN_W-1:0] sine_next;

  // mirror the fraction in odd quadrants
  always_comb begin
    rr   = angle[ANGLE_WIDTH-2] ? QUARTER - RW'(angle[ANGLE_WIDTH-3:0])
                                : RW'(angle[ANGLE_WIDTH-3:0]);
    t_in = {rr, {PAD{1'b0}}};
  end

  always_comb begin
    pr        = mul_q30(acc_q[5], t_q[5]);
    rsum      = 32'(pr) + 32'(ROUND_HALF);
    rnd       = rsum[31:15];
    mag       = (rnd > 17'(SIN_MAX)) ? 15'(SIN_MAX) : rnd[14:0];
    sine_next = neg_q[5] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      t_q[0]   <= t_in;
      neg_q[0] <= angle[ANGLE_WIDTH-1];
    end
    if (adv[1]) begin
      t_q[1]   <= t_q[0];
      neg_q[1] <= neg_q[0];
      t2_q[1]  <= mul_q30(t_q[0], t_q[0]);
    end
    if (adv[2]) begin
      t_q[2]   <= t_q[1];
      neg_q[2] <= neg_q[1];
      t2_q[2]  <= t2_q[1];
      acc_q[2] <= HORNER_K[0] - mul_q30(K_C9, t2_q[1]);
    end
    for (int k = 3; k < 6; k++) begin
      if (adv[k]) begin
        t_q[k]   <= t_q[k-1];
        neg_q[k] <= neg_q[k-1];
        t2_q[k]  <= t2_q[k-1];
        acc_q[k] <= HORNER_K[k-2] - mul_q30(acc_q[k-1], t2_q[k-1]);
      end
    end
    if (adv[6]) begin
      sine <= sine_next;
    end
  end

endmodule

// ----- design/tcer_centroid.sv -----
`timescale 1ns / 1ps
module tcer_centroid
  import tcer_pkg::*;
#(
  parameter int COORD_WIDTH = 32
) (
  input  logic                                  clk,
  input  logic [CEN_STAGES-1:0]                 adv,
  input  logic [8:0][COORD_WIDTH-1:0]           v,
  output logic [2:0][COORD_WIDTH:0]             cen,
  output logic [8:0][COORD_WIDTH+DEXT-1:0]      d
);

  localparam int CW = COORD_WIDTH;
  localparam int DW = COORD_WIDTH + DEXT;
  localparam int N  = COORD_WIDTH + 1;
  localparam int H  = (N + 1) / 2;
  // ceil(2^(N+1) / 3): exact quotient by 3 for any N-bit magnitude
  localparam longint RECIP_L = ((longint'(1) << (N + 1)) + 2) / 3;
  localparam logic [N-1:0] RECIP = N'(RECIP_L);

  logic [8:0][CW-1:0]    vr0, vr1, vr2, vr3;
  logic [2:0]            neg1, neg2;
  logic [2:0][N-1:0]     mag1;
  logic [2:0][H+N-1:0]   pl2;
  logic [2:0][2*N-H-1:0] ph2;
  logic [2:0][CW:0]      cen3;
  logic signed [CW+1:0]  sum   [3];
  logic [2:0][N-1:0]     mag_c;
  logic [2:0][CW:0]      cen_c;
  logic [2*N-1:0]        full  [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sum[k] = (CW+2)'($signed(vr0[k])) + (CW+2)'($signed(vr0[k+3]))
             + (CW+2)'($signed(vr0[k+6]));
      mag_c[k] = sum[k][CW+1] ? N'(-sum[k]) : N'(sum[k]);
      full[k]  = ((2*N)'(ph2[k]) << H) + (2*N)'(pl2[k]);
      cen_c[k] = neg2[k] ? -{1'b0, full[k][2*N-1:N+1]} : {1'b0, full[k][2*N-1:N+1]};
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      vr0 <= v;
    end
    if (adv[1]) begin
      vr1 <= vr0;
      for (int k = 0; k < 3; k++) begin
        neg1[k] <= sum[k][CW+1];
        mag1[k] <= mag_c[k];
      end
    end
    if (adv[2]) begin
      vr2  <= vr1;
      neg2 <= neg1;
      for (int k = 0; k < 3; k++) begin
        pl2[k] <= (H+N)'(mag1[k][H-1:0]) * (H+N)'(RECIP);
        ph2[k] <= (2*N-H)'(mag1[k][N-1:H]) * (2*N-H)'(RECIP);
      end
    end
    if (adv[3]) begin
      vr3  <= vr2;
      cen3 <= cen_c;
    end
    if (adv[4]) begin
      cen <= cen3;
      for (int i = 0; i < 9; i++) begin
        d[i] <= DW'($signed(vr3[i])) - DW'($signed(cen3[i%3]));
      end
    end
  end

endmodule

// ----- design/tcer_rot.sv -----
`timescale 1ns / 1ps
module tcer_rot
  import tcer_pkg::*;
#(
  parameter int COORD_WIDTH = 32
) (
  input  logic                             clk,
  input  logic [1:0]                       adv,
  input  sc_t                              sc,
  input  logic [2:0][COORD_WIDTH+DEXT-1:0] a,
  input  logic [2:0][COORD_WIDTH+DEXT-1:0] b,
  output logic [2:0][COORD_WIDTH+DEXT-1:0] a_out,
  output logic [2:0][COORD_WIDTH+DEXT-1:0] b_out
);

  // a' = c*a - s*b, b' = s*a + c*b, each rounded half up from Q.15
  localparam int DW = COORD_WIDTH + DEXT;
  localparam int PW = DW + SIN_W;

  logic [2:0][PW-1:0] ca, sb, sa, cb;
  logic signed [PW:0] s1 [3];
  logic signed [PW:0] s2 [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s1[i] = (PW+1)'($signed(ca[i])) - (PW+1)'($signed(sb[i])) + (PW+1)'(ROUND_HALF);
      s2[i] = (PW+1)'($signed(sa[i])) + (PW+1)'($signed(cb[i])) + (PW+1)'(ROUND_HALF);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (adv[0]) begin
        ca[i] <= PW'($signed(a[i])) * PW'(sc.cos_v);
        sb[i] <= PW'($signed(b[i])) * PW'(sc.sin_v);
        sa[i] <= PW'($signed(a[i])) * PW'(sc.sin_v);
        cb[i] <= PW'($signed(b[i])) * PW'(sc.cos_v);
      end
      if (adv[1]) begin
        a_out[i] <= s1[i][DW+FRAC-1:FRAC];
        b_out[i] <= s2[i][DW+FRAC-1:FRAC];
      end
    end
  end

endmodule

// ----- design/triangle_centroid_euler_rotate_unit.sv -----
`timescale 1ns / 1ps
// Rotates one triangle about its centroid, about Z, then Y, then X, and returns
// the three vertices saturated to the coordinate range. A triangle enters on every
// clock when the output side is not stalled; the pipeline is made of the sine
// polynomial (a multiplier in each stage after the input register) followed by two stages
// per rotation axis and the final add-and-saturate stage. Each stage holds its beat
// only while the stage after it is full and holding, so gaps close up under back-pressure.
module triangle_centroid_euler_rotate_unit
  import tcer_pkg::*;
#(
  parameter int COORD_WIDTH = 32,
  parameter int ANGLE_WIDTH = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z,
  // angle_about_x, angle_about_y, angle_about_z, zero fill
  input  logic [((9*COORD_WIDTH+3*ANGLE_WIDTH+7)/8)*8-1:0] s_tdata,
  output logic m_tvalid,
  input  logic m_tready,
  // r0_x, r0_y, r0_z, r1_x, r1_y, r1_z, r2_x, r2_y, r2_z, zero fill
  output logic [((9*COORD_WIDTH+7)/8)*8-1:0] m_tdata
);

  localparam int CW    = COORD_WIDTH;
  localparam int AW    = ANGLE_WIDTH;
  localparam int DW    = COORD_WIDTH + DEXT;
  localparam int OUT_W = ((9*COORD_WIDTH+7)/8)*8;
  localparam logic [AW-1:0] QTR = AW'(1) << (AW - 2);

  logic [NSTAGE-1:0] vld, rdy;

  logic [8:0][CW-1:0] v;
  logic [AW-1:0] ang_x, ang_y, ang_z;
  logic signed [SIN_W-1:0] sin_x, cos_x, sin_y, cos_y, sin_z, cos_z;

  logic [2:0][CW:0]     cen4;
  logic [2:0][CW:0]     cen_q [5:12];
  logic [8:0][DW-1:0]   d4, d5, d6;
  logic [2:0][DW-1:0]   za, zb, zc7, zc8;
  logic [2:0][DW-1:0]   zx8, zy8, yy9, yy10, yz10, yx10, xx11, xx12, xy12, xz12;
  sc_t                  scz;
  sc_t                  scy7, scy8;
  sc_t                  scx_q [7:10];
  logic [8:0][CW-1:0]   out_q;

  function automatic logic [CW-1:0] sat(input logic [DW-1:0] off, input logic [CW:0] c);
    logic signed [DW:0] r;
    r = (DW+1)'($signed(off)) + (DW+1)'($signed(c));
    if (r[DW:CW-1] == '0 || r[DW:CW-1] == '1) begin
      return r[CW-1:0];
    end else if (r[DW]) begin
      return {1'b1, {(CW-1){1'b0}}};
    end else begin
      return {1'b0, {(CW-1){1'b1}}};
    end
  endfunction

  // handshake: a stage advances when empty or when the next stage advances
  always_comb begin
    rdy[NSTAGE-1] = !vld[NSTAGE-1] || m_tready;
    for (int i = NSTAGE - 2; i >= 0; i--) begin
      rdy[i] = !vld[i] || rdy[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int i = 0; i < NSTAGE; i++) begin
        if (rdy[i]) begin
          vld[i] <= (i == 0) ? s_tvalid : vld[(i == 0) ? 0 : i-1];
        end
      end
    end
  end

  assign s_tready = rdy[0];
  assign m_tvalid = vld[NSTAGE-1];
  assign m_tdata  = OUT_W'(out_q);

  always_comb begin
    for (int j = 0; j < 9; j++) begin
      v[j] = s_tdata[j*CW +: CW];
    end
    ang_x = s_tdata[9*CW +: AW];
    ang_y = s_tdata[9*CW+AW +: AW];
    ang_z = s_tdata[9*CW+2*AW +: AW];
  end

  tcer_sine #(.ANGLE_WIDTH(AW)) u_sin_x (.clk, .adv(rdy[6:0]), .angle(ang_x), .sine(sin_x));
  tcer_sine #(.ANGLE_WIDTH(AW)) u_cos_x (.clk, .adv(rdy[6:0]), .angle(ang_x + QTR),
                                         .sine(cos_x));
  tcer_sine #(.ANGLE_WIDTH(AW)) u_sin_y (.clk, .adv(rdy[6:0]), .angle(ang_y), .sine(sin_y));
  tcer_sine #(.ANGLE_WIDTH(AW)) u_cos_y (.clk, .adv(rdy[6:0]), .angle(ang_y + QTR),
                                         .sine(cos_y));
  tcer_sine #(.ANGLE_WIDTH(AW)) u_sin_z (.clk, .adv(rdy[6:0]), .angle(ang_z), .sine(sin_z));
  tcer_sine #(.ANGLE_WIDTH(AW)) u_cos_z (.clk, .adv(rdy[6:0]), .angle(ang_z + QTR),
                                         .sine(cos_z));

  tcer_centroid #(.COORD_WIDTH(CW)) u_centroid (
    .clk,
    .adv (rdy[4:0]),
    .v,
    .cen (cen4),
    .d   (d4)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      za[i] = d6[3*i];
      zb[i] = d6[3*i+1];
    end
    scz.sin_v = sin_z;
    scz.cos_v = cos_z;
  end

  // hold offsets, centroid, later axes' sine/cosine and the untouched axis
  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      d5       <= d4;
      cen_q[5] <= cen4;
    end
    if (rdy[6]) begin
      d6 <= d5;
    end
    for (int i = 6; i < 13; i++) begin
      if (rdy[i]) begin
        cen_q[i] <= cen_q[i-1];
      end
    end
    if (rdy[7]) begin
      for (int i = 0; i < 3; i++) begin
        zc7[i] <= d6[3*i+2];
      end
      scy7     <= '{sin_v: sin_y, cos_v: cos_y};
      scx_q[7] <= '{sin_v: sin_x, cos_v: cos_x};
    end
    if (rdy[8]) begin
      zc8      <= zc7;
      scy8     <= scy7;
      scx_q[8] <= scx_q[7];
    end
    if (rdy[9]) begin
      yy9      <= zy8;
      scx_q[9] <= scx_q[8];
    end
    if (rdy[10]) begin
      yy10      <= yy9;
      scx_q[10] <= scx_q[9];
    end
    if (rdy[11]) begin
      xx11 <= yx10;
    end
    if (rdy[12]) begin
      xx12 <= xx11;
    end
    if (rdy[13]) begin
      for (int i = 0; i < 3; i++) begin
        out_q[3*i]   <= sat(DW'(xx12[i]), cen_q[12][0]);
        out_q[3*i+1] <= sat(DW'(xy12[i]), cen_q[12][1]);
        out_q[3*i+2] <= sat(DW'(xz12[i]), cen_q[12][2]);
      end
    end
  end

  // Z: (x, y)
  tcer_rot #(.COORD_WIDTH(CW)) u_rot_z (
    .clk, .adv(rdy[8:7]), .sc(scz),
    .a(za), .b(zb), .a_out(zx8), .b_out(zy8)
  );

  // Y: (z, x)
  tcer_rot #(.COORD_WIDTH(CW)) u_rot_y (
    .clk, .adv(rdy[10:9]), .sc(scy8),
    .a(zc8), .b(zx8), .a_out(yz10), .b_out(yx10)
  );

  // X: (y, z)
  tcer_rot #(.COORD_WIDTH(CW)) u_rot_x (
    .clk, .adv(rdy[12:11]), .sc(scx_q[10]),
    .a(yy10), .b(yz10), .a_out(xy12), .b_out(xz12)
  );

`ifndef NO_ASSERTIONS
  a_beat_count: assert property (@(posedge clk) disable iff (rst)
    !rst |=> $countones(vld) == $past($countones(vld)) + int'($past(s_tvalid && s_tready))
                                - int'($past(m_tvalid && m_tready)))
    else $error("beat lost or duplicated in pipeline");

  a_sincos_norm: assert property (@(posedge clk) disable iff (rst)
    vld[6] |-> (longint'(sin_x) * longint'(sin_x) + longint'(cos_x) * longint'(cos_x)
                >= 64'sd1073479680)
            && (longint'(sin_x) * longint'(sin_x) + longint'(cos_x) * longint'(cos_x)
                <= 64'sd1074003968))
    else $error("sine and cosine of X angle out of step");
`endif

endmodule
